[sv/lgs_pkg.sv]
// Shared types and constants for the life generation step block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

	// Default board limits, handed to the top level as parameter defaults.
	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 64;

	// Width of the board size registers and of the pattern size fields.
	localparam int DIM_W = 7;
	localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_BOARD_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOARD_HEIGHT = 2'd1;

	// Command opcodes; the fourth code does nothing.
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_STEP  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// One command request.
	typedef struct packed {
		logic [1:0]       opcode;
		logic [5:0]       pos_x;
		logic [5:0]       pos_y;
		logic [5:0]       pat_col;
		logic [5:0]       pat_row;
		logic [DIM_W-1:0] pat_width;
		logic [DIM_W-1:0] pat_height;
		logic             cell_value;
	} cmd_t;

	// One result request.
	typedef struct packed {
		logic read_value;
		logic accepted;
	} res_t;

	// Board memory port strobes.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CELL_WR,
		ST_RD_PICK,
		ST_GEN_FIRST,
		ST_GEN_ROW,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

[sv/lgs_board_mem.sv]
// Board row memory: one row per entry, one read and one write port, registered read.
// Per-row valid bits make never-written rows read as all dead. Depends on lgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgs_board_mem
	import lgs_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	localparam int RW = $clog2(MAX_HEIGHT)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mem_ctl_t             ctl,
	input  wire logic [RW-1:0]        rd_addr,
	input  wire logic [RW-1:0]        wr_addr,
	input  wire logic [MAX_WIDTH-1:0] wr_data,
	output logic      [MAX_WIDTH-1:0] rd_data
);

	logic [MAX_WIDTH-1:0]  mem_q [MAX_HEIGHT];
	logic [MAX_HEIGHT-1:0] row_valid_q;
	logic [MAX_WIDTH-1:0]  rd_raw_s1;
	logic                  rd_valid_s1;

	// Row storage and the registered read port.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_raw_s1 <= mem_q[rd_addr];
		end
	end

	// A row becomes valid on its first write; reset marks every row dead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_valid_s1 <= row_valid_q[rd_addr];
			end
		end
	end

	// A row that was never written reads as all dead.
	assign rd_data = rd_valid_s1 ? rd_raw_s1 : '0;

`ifndef SYNTH
	// The sequencer never reads the row it writes in the same cycle.
	a_no_same_row: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.rd_en && ctl.wr_en) |-> (rd_addr != wr_addr))
		else $error("board memory read and write hit the same row");

	// Addresses stay on the board.
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.rd_en || ctl.wr_en) |->
		((32'(rd_addr) < MAX_HEIGHT) || !ctl.rd_en) && ((32'(wr_addr) < MAX_HEIGHT) || !ctl.wr_en))
		else $error("board memory address beyond the last row");

	// A written row is valid from the next cycle on.
	a_row_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |=> row_valid_q[$past(wr_addr)])
		else $error("written row not marked valid");
`endif

endmodule

`default_nettype wire

[sv/lgs_row_calc.sv]
// One board row through the B3/S23 rule, from the old rows above, current and below.
// Columns at or beyond the width in use keep their value. Depends on lgs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgs_row_calc
	import lgs_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic [MAX_WIDTH-1:0] above,
	input  wire logic [MAX_WIDTH-1:0] cur,
	input  wire logic [MAX_WIDTH-1:0] below,
	input  wire logic [DIM_W-1:0]     width,
	output logic      [MAX_WIDTH-1:0] new_row
);

	localparam logic [3:0] NBR_KEEP  = 4'd2;
	localparam logic [3:0] NBR_BIRTH = 4'd3;

	logic [MAX_WIDTH-1:0] col_mask;
	logic [MAX_WIDTH-1:0] a_m, c_m, b_m;
	logic [MAX_WIDTH-1:0] a_l, a_r, c_l, c_r, b_l, b_r;
	logic [3:0]           nbr_cnt [MAX_WIDTH];

	// Columns in use; cells beyond them never count as neighbors.
	always_comb begin
		for (int x = 0; x < MAX_WIDTH; x++) begin
			col_mask[x] = ({1'b0, width} > 8'(x));
		end
	end

	// Left and right neighbors by shifting the masked rows; the edges shift in dead cells.
	always_comb begin
		a_m = above & col_mask;
		c_m = cur & col_mask;
		b_m = below & col_mask;
		a_l = a_m << 1;
		a_r = a_m >> 1;
		c_l = c_m << 1;
		c_r = c_m >> 1;
		b_l = b_m << 1;
		b_r = b_m >> 1;
	end

	// Neighbor count and rule for every column.
	always_comb begin
		for (int x = 0; x < MAX_WIDTH; x++) begin
			nbr_cnt[x] = 4'(a_l[x]) + 4'(a_m[x]) + 4'(a_r[x]) + 4'(c_l[x]) + 4'(c_r[x])
				+ 4'(b_l[x]) + 4'(b_m[x]) + 4'(b_r[x]);
			if (col_mask[x]) begin
				new_row[x] = (nbr_cnt[x] == NBR_BIRTH) || (cur[x] && (nbr_cnt[x] == NBR_KEEP));
			end else begin
				new_row[x] = cur[x];
			end
		end
	end

endmodule

`default_nettype wire

[sv/life_generation_step.sv]
// Top level of the life generation step block: command sequencer, size registers,
// row buffers and result register. Depends on lgs_pkg, lgs_board_mem, lgs_row_calc.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------
//   cmd     | cmd_valid, cmd_stall | cmd (cmd_t), into the block
//   res     | res_valid, res_stall | res (res_t), out of the block
//   cfg     | cfg_valid, cfg_ready | cfg_index, cfg_data, into the block
//
// One command at a time. A stored cell write or a board read passes its own state, a step
// walks one row per cycle through the neighbor logic, a rejected or unknown command
// goes straight to the finishing state; the next command is taken as its result appears.
// Reset clears the board through per-row valid bits, so no clearing pass follows it.
// A stalled result holds in the output register while the next command runs; that command
// then waits in its finishing state, stalling the input, until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module life_generation_step
	import lgs_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	output logic                      cmd_stall,
	input  wire cmd_t                 cmd,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output res_t                      res,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data
);

	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int YW = $clog2(MAX_HEIGHT + 1);

	state_t               state_q, state_d;
	cmd_t                 cmd_q;
	logic [DIM_W-1:0]     bw_q, bh_q;
	logic [DIM_W-1:0]     w_eff, h_eff;
	logic [YW-1:0]        y_q;
	logic [YW:0]          y_p1, y_p2, h_cmp;
	logic                 next_live, more_read;
	logic [MAX_WIDTH-1:0] above_q, cur_q;
	logic [MAX_WIDTH-1:0] below_row, new_row, mem_rd_data, bit_sel, rd_shift;
	mem_ctl_t             mctl;
	logic [RW-1:0]        rd_addr, wr_addr;
	logic [MAX_WIDTH-1:0] wr_data;
	res_t                 result_q, res_data_q;
	logic                 res_valid_q;
	logic                 cmd_accept, out_free;
	logic [DIM_W-1:0]     cell_col, cell_row;

	// Whole pattern fits, origin on the board and offset inside the pattern.
	function automatic logic write_fits(input cmd_t c, input logic [DIM_W-1:0] w,
		input logic [DIM_W-1:0] h);
		logic [DIM_W:0] x_end;
		logic [DIM_W:0] y_end;
		x_end = {2'b00, c.pos_x} + {1'b0, c.pat_width};
		y_end = {2'b00, c.pos_y} + {1'b0, c.pat_height};
		return ({1'b0, c.pos_x} < w) && ({1'b0, c.pos_y} < h)
			&& (x_end <= {1'b0, w}) && (y_end <= {1'b0, h})
			&& ({1'b0, c.pat_col} < c.pat_width) && ({1'b0, c.pat_row} < c.pat_height);
	endfunction

	// Cell position lies on the board in use.
	function automatic logic on_board(input cmd_t c, input logic [DIM_W-1:0] w,
		input logic [DIM_W-1:0] h);
		return ({1'b0, c.pos_x} < w) && ({1'b0, c.pos_y} < h);
	endfunction

	// Sizes in use, limited to the board storage.
	assign w_eff = ({1'b0, bw_q} > 8'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : bw_q;
	assign h_eff = ({1'b0, bh_q} > 8'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : bh_q;

	// Row counter arithmetic for the generation walk.
	assign h_cmp     = {1'b0, YW'(h_eff)};
	assign y_p1      = {1'b0, y_q} + (YW + 1)'(1);
	assign y_p2      = {1'b0, y_q} + (YW + 1)'(2);
	assign next_live = (y_p1 < h_cmp);
	assign more_read = (y_p2 < h_cmp);
	assign below_row = next_live ? mem_rd_data : '0;

	// Target cell of a pattern write.
	assign cell_col = {1'b0, cmd_q.pos_x} + {1'b0, cmd_q.pat_col};
	assign cell_row = {1'b0, cmd_q.pos_y} + {1'b0, cmd_q.pat_row};
	assign bit_sel  = MAX_WIDTH'(1) << cell_col;
	assign rd_shift = mem_rd_data >> cmd_q.pos_x;

	// Handshakes.
	assign cmd_stall  = (state_q != ST_IDLE);
	assign cmd_accept = cmd_valid && !cmd_stall;
	assign out_free   = !res_valid_q || !res_stall;
	assign cfg_ready  = 1'b1;
	assign res_valid  = res_valid_q;
	assign res        = res_data_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q <= DIM_RESET;
			bh_q <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BOARD_WIDTH:  bw_q <= cfg_data;
				CFG_BOARD_HEIGHT: bh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.opcode)
						OP_WRITE: state_d = write_fits(cmd, w_eff, h_eff) ? ST_CELL_WR : ST_DONE;
						OP_READ:  state_d = on_board(cmd, w_eff, h_eff) ? ST_RD_PICK : ST_DONE;
						OP_STEP:  state_d = ((w_eff != '0) && (h_eff != '0)) ? ST_GEN_FIRST : ST_DONE;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_CELL_WR:   state_d = ST_DONE;
			ST_RD_PICK:   state_d = ST_DONE;
			ST_GEN_FIRST: state_d = ST_GEN_ROW;
			ST_GEN_ROW: begin
				if (!next_live) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory strobes and addresses for each state.
	always_comb begin
		mctl    = '0;
		rd_addr = '0;
		wr_addr = '0;
		wr_data = new_row;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.opcode)
						OP_WRITE: begin
							mctl.rd_en = write_fits(cmd, w_eff, h_eff);
							rd_addr    = RW'({1'b0, cmd.pos_y} + {1'b0, cmd.pat_row});
						end
						OP_READ: begin
							mctl.rd_en = on_board(cmd, w_eff, h_eff);
							rd_addr    = RW'(cmd.pos_y);
						end
						OP_STEP: begin
							mctl.rd_en = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ST_CELL_WR: begin
				mctl.wr_en = 1'b1;
				wr_addr    = RW'(cell_row);
				wr_data    = (mem_rd_data & ~bit_sel) | (cmd_q.cell_value ? bit_sel : '0);
			end
			ST_GEN_FIRST: begin
				mctl.rd_en = next_live;
				rd_addr    = RW'(y_p1);
			end
			ST_GEN_ROW: begin
				mctl.wr_en = 1'b1;
				wr_addr    = RW'(y_q);
				mctl.rd_en = more_read;
				rd_addr    = RW'(y_p2);
			end
			default: ;
		endcase
	end

	// State and row counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			y_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cmd_accept) begin
				y_q <= '0;
			end else if (state_q == ST_GEN_ROW) begin
				y_q <= YW'(y_p1);
			end
		end
	end

	// Command copy, row buffers and the pending result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_accept) begin
					cmd_q               <= cmd;
					above_q             <= '0;
					result_q.read_value <= 1'b0;
					result_q.accepted   <= (cmd.opcode == OP_STEP) || (cmd.opcode == OP_READ);
				end
			end
			ST_CELL_WR: begin
				result_q.accepted <= 1'b1;
			end
			ST_RD_PICK: begin
				result_q.read_value <= rd_shift[0];
			end
			ST_GEN_FIRST: begin
				cur_q <= mem_rd_data;
			end
			ST_GEN_ROW: begin
				above_q <= cur_q;
				cur_q   <= below_row;
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			res_data_q <= result_q;
		end
	end

	lgs_board_mem #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_board_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (mem_rd_data)
	);

	lgs_row_calc #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_row_calc (
		.above   (above_q),
		.cur     (cur_q),
		.below   (below_row),
		.width   (w_eff),
		.new_row (new_row)
	);

`ifndef SYNTH
	// An accepted command always leaves idle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_accept |=> (state_q != ST_IDLE))
		else $error("accepted command did not start");

	// The generation walk never passes the last row in use.
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GEN_ROW) |-> ({1'b0, y_q} < h_cmp))
		else $error("row counter beyond the board height");

	// A result appears only after the finishing state.
	a_res_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> ($past(state_q) == ST_DONE))
		else $error("result shown without a finished command");

	// A live read value only comes with an accepted command.
	a_read_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.read_value) |-> res.accepted)
		else $error("read value set on a rejected command");
`endif

endmodule

`default_nettype wire
